// ===== rtl/bsda_pkg.sv =====
// ----------------------------------------------------------------------------
// bsda_pkg : shared types and constants for the bounded stack
// Capacity, derived widths, operation and status codes, word formats.
// ----------------------------------------------------------------------------
package bsda_pkg;

   localparam int CAPACITY = 8;

   // count runs 0..CAPACITY, index runs 0..CAPACITY-1
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // common width for comparing the 4-bit position against the count
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_PEEK  = 3'd2,
      OP_WRITE = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  position;
      logic [31:0] data_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      status_type  status;
      logic [3:0]  entry_count;
      logic        full_flag;
      logic        empty_flag;
   } rsp_word_type;

endpackage

// ===== rtl/bsda_if.sv =====
// ----------------------------------------------------------------------------
// bsda_if : valid/ready channels for the bounded stack
// One interface for request words, one for response words.
// ----------------------------------------------------------------------------
interface bsda_req_if import bsda_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bsda_rsp_if import bsda_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/bounded_stack_with_depth_access.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_depth_access : LIFO stack with access by depth
// Push, pop, peek at depth, overwrite at depth and clear on a word store.
// ----------------------------------------------------------------------------
// A request word is taken at a clock edge and its response word is registered
// at that same edge, so the block sustains one word per cycle while the
// response side takes every word. The response sits in an output register;
// a request is taken when that register is empty or being drained in the
// same cycle. All state updates (top pointer, store write) happen at the
// edge a request is taken; a peek reads the store at that same edge into a
// read-data register (a synchronous read). Since at most one
// request is taken per edge and a request either writes or reads the store,
// never both, back-to-back words see each other's results with no stall or
// forwarding. Depth 1 is the top entry. Stack entries are not cleared on
// reset or clear; only entries below the top pointer are ever read.
// Status codes: ok, full (push on full stack), empty (pop or peek on empty
// stack), range (peek or overwrite at depth 0 or deeper than the count).
// Unused operation codes return ok and change nothing.
// ----------------------------------------------------------------------------
module bounded_stack_with_depth_access
   import bsda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   bsda_req_if.sink          req_if,
   bsda_rsp_if.source        rsp_if
);

   // stack store, one write and one read port
   logic [31:0]      mem [CAPACITY];

   // top pointer (entry count)
   logic [CNT_W-1:0] top_ff;
   logic [CNT_W-1:0] top_in;

   // output register
   logic             rsp_valid_ff;
   status_type       status_ff;
   status_type       status_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             peek_ok_ff;
   logic             peek_ok_in;
   logic [31:0]      rd_ff;

   logic             accept;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] depth_idx;
   logic             pos_ok;
   logic             empty;
   logic             full;
   logic [CMP_W-1:0] pos_wide;
   logic [CMP_W-1:0] top_wide;
   logic [CMP_W-1:0] cnt_wide;

   // free slot or slot draining this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign empty    = (top_ff == '0);
   assign full     = (top_ff == CNT_W'(CAPACITY));
   assign pos_wide = CMP_W'(req_if.payload.position);
   assign top_wide = CMP_W'(top_ff);
   assign pos_ok   = (pos_wide != '0) && (pos_wide <= top_wide);
   // top - pos is below CAPACITY whenever the position is valid
   assign depth_idx = IDX_W'(top_wide - pos_wide);

   always_comb begin
      top_in     = top_ff;
      status_in  = ST_OK;
      wr_en      = 1'b0;
      wr_idx     = depth_idx;
      peek_ok_in = 1'b0;
      case (op_type'(req_if.payload.operation))
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en  = 1'b1;
               wr_idx = IDX_W'(top_ff);
               top_in = top_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               top_in = top_ff - CNT_W'(1);
            end
         end
         OP_PEEK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!pos_ok) begin
               status_in = ST_RANGE;
            end else begin
               peek_ok_in = 1'b1;
            end
         end
         OP_WRITE: begin
            if (!pos_ok) begin
               status_in = ST_RANGE;
            end else begin
               wr_en = 1'b1;
            end
         end
         OP_CLEAR: begin
            top_in = '0;
         end
         default: begin
         end
      endcase
   end

   // store: write port and registered read port
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         mem[wr_idx] <= req_if.payload.data_in;
      end
      if (accept && peek_ok_in) begin
         rd_ff <= mem[depth_idx];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            top_ff <= top_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         cnt_ff     <= top_in;
         peek_ok_ff <= peek_ok_in;
      end
   end

   assign cnt_wide = CMP_W'(cnt_ff);

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.payload.read_data   = peek_ok_ff ? rd_ff : 32'd0;
   assign rsp_if.payload.status      = status_ff;
   assign rsp_if.payload.entry_count = cnt_wide[3:0];
   assign rsp_if.payload.full_flag   = (cnt_ff == CNT_W'(CAPACITY));
   assign rsp_if.payload.empty_flag  = (cnt_ff == '0);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the bounded stack with depth access
// Drives request words through a valid/ready channel, mirrors the stack in
// a shadow copy to predict each response word, and compares every response
// field by field. Directed corner words come first, then randomized
// segments that swing the stack between empty and full, with random
// back-pressure and request gaps.
// ----------------------------------------------------------------------------
module tb_top;
   import bsda_pkg::*;

   // -------------------------------------------------------------------------
   // Shadow stack and response checker.
   // note_request() applies an accepted request word to the shadow copy and
   // queues the response word it must produce; check_reply() pops the oldest
   // queued response and compares it with what the block returned.
   // -------------------------------------------------------------------------
   class stack_tracker;
      logic [31:0]  shadow_words [CAPACITY];
      int unsigned  shadow_count;
      rsp_word_type awaited_replies [$];
      int unsigned  failures;

      function new();
         shadow_count = 0;
         failures     = 0;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         logic         pos_ok;
         int unsigned  slot;
         r        = '0;
         r.status = ST_OK;
         // depth 1 is the top, so the slot counts down from the count
         pos_ok = (w.position >= 1) && (w.position <= shadow_count);
         slot   = pos_ok ? shadow_count - w.position : 0;
         case (w.operation)
            OP_PUSH: begin
               if (shadow_count >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  shadow_words[shadow_count] = w.data_in;
                  shadow_count++;
               end
            end
            OP_POP: begin
               if (shadow_count == 0) r.status = ST_EMPTY;
               else shadow_count--;
            end
            OP_PEEK: begin
               if (shadow_count == 0) r.status = ST_EMPTY;
               else if (!pos_ok) r.status = ST_RANGE;
               else r.read_data = shadow_words[slot];
            end
            OP_WRITE: begin
               // an empty stack lands here too: no position is valid
               if (!pos_ok) r.status = ST_RANGE;
               else shadow_words[slot] = w.data_in;
            end
            OP_CLEAR: shadow_count = 0;
            default: ;  // unused codes: ok, no change
         endcase
         r.entry_count = 4'(shadow_count);
         r.full_flag   = (shadow_count == CAPACITY);
         r.empty_flag  = (shadow_count == 0);
         awaited_replies.push_back(r);
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_reply(rsp_word_type got);
         rsp_word_type want;
         if (awaited_replies.size() == 0) begin
            failures++;
            $display("%0t: response word with none expected, expected nothing, actual %0h",
                     $time, got);
            return;
         end
         want = awaited_replies.pop_front();
         field_check("read_data", want.read_data, got.read_data);
         field_check("status", 32'(want.status), 32'(got.status));
         field_check("entry_count", 32'(want.entry_count), 32'(got.entry_count));
         field_check("full_flag", 32'(want.full_flag), 32'(got.full_flag));
         field_check("empty_flag", 32'(want.empty_flag), 32'(got.empty_flag));
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idling;   // random gaps / stalls enabled on both sides

   bsda_req_if req_if ();
   bsda_rsp_if rsp_if ();

   stack_tracker tracker;

   bounded_stack_with_depth_access u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest legal run (~1.5k words, each at
   // worst a full request gap plus a full response stall).
   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Monitor: sample both handshakes at the edge. A response accepted at
   // this edge always belongs to an earlier request, so check before noting.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) tracker.check_reply(rsp_if.payload);
         if (req_if.valid && req_if.ready) tracker.note_request(req_if.payload);
      end
   end

   // Response side back-pressure: random stall bursts while idling is on,
   // otherwise ready stays high.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idling && !reset && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Present one request word and hold it until taken; then maybe drop
   // valid for a random gap. Valid is never lowered and raised in one step.
   task automatic send_word(input logic [2:0] op, input logic [3:0] pos,
                            input logic [31:0] data);
      req_word_type w;
      w.operation = op;
      w.position  = pos;
      w.data_in   = data;
      req_if.valid   <= 1'b1;
      req_if.payload <= w;
      do @(posedge clock); while (!req_if.ready);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 19))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int          sent;
      int          seg_len;
      int unsigned push_pct;
      int unsigned roll;
      logic [2:0]  op;
      logic [3:0]  pos;

      tracker        = new();
      idling         = 1'b1;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed corners ----
      send_word(OP_POP, 4'd0, 32'h0);                 // pop on empty
      send_word(OP_PEEK, 4'd1, 32'h0);                // peek on empty
      send_word(OP_WRITE, 4'd1, 32'hDEAD_BEEF);       // overwrite on empty
      send_word(OP_PUSH, 4'd0, 32'h0000_0000);        // fill to capacity
      send_word(OP_PUSH, 4'd15, 32'hFFFF_FFFF);
      send_word(OP_PUSH, 4'd0, 32'h8000_0001);
      send_word(OP_PUSH, 4'd0, 32'h5555_AAAA);
      send_word(OP_PUSH, 4'd0, 32'hAAAA_5555);
      send_word(OP_PUSH, 4'd0, 32'h0123_4567);
      send_word(OP_PUSH, 4'd0, 32'h89AB_CDEF);
      send_word(OP_PUSH, 4'd0, 32'h7FFF_FFFE);
      send_word(OP_PUSH, 4'd0, 32'h1111_1111);        // push on full
      send_word(OP_PEEK, 4'd1, 32'h0);                // top entry
      send_word(OP_PEEK, 4'd8, 32'h0);                // bottom entry
      send_word(OP_PEEK, 4'd0, 32'h0);                // depth zero
      send_word(OP_PEEK, 4'd15, 32'h0);               // deeper than count
      send_word(OP_PEEK, 4'd9, 32'h0);
      send_word(OP_WRITE, 4'd8, 32'hCAFE_F00D);       // overwrite bottom
      send_word(OP_WRITE, 4'd0, 32'hFFFF_FFFF);       // overwrite depth zero
      send_word(OP_PEEK, 4'd8, 32'hFFFF_FFFF);        // see the overwrite
      send_word(3'd5, 4'd3, 32'hFFFF_FFFF);           // unused codes
      send_word(3'd7, 4'd15, 32'h0);
      send_word(OP_POP, 4'd0, 32'h0);
      send_word(OP_CLEAR, 4'd0, 32'h0);
      send_word(OP_CLEAR, 4'd0, 32'h0);               // clear when empty

      // ---- randomized segments ----
      // Each segment leans toward push or pop so the stack keeps swinging
      // between empty and full. The last stretch runs with no idling.
      sent = 0;
      while (sent < 1400) begin
         seg_len = $urandom_range(40, 80);
         case ($urandom_range(0, 2))
            0:       push_pct = 80;
            1:       push_pct = 50;
            default: push_pct = 20;
         endcase
         idling = (sent < 1200) && ($urandom_range(0, 3) != 0);
         repeat (seg_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               op = 3'($urandom_range(5, 7));
            end else if (roll < 5) begin
               op = OP_CLEAR;
            end else if ($urandom_range(0, 99) < push_pct) begin
               op = OP_PUSH;
            end else begin
               roll = $urandom_range(0, 9);
               op = (roll < 4) ? OP_POP : (roll < 7) ? OP_PEEK : OP_WRITE;
            end
            // mostly legal depths, some anywhere in the 4-bit field
            if ($urandom_range(0, 3) == 0) pos = 4'($urandom_range(0, 15));
            else pos = 4'($urandom_range(1, CAPACITY));
            send_word(op, pos, pick_data());
            if (op <= OP_CLEAR) sent++;
         end
      end

      // ---- drain ----
      idling = 1'b0;
      req_if.valid <= 1'b0;
      while (tracker.awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);   // catch any stray response word

      if (tracker.failures == 0 && tracker.awaited_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
